>>> hdl/vector_direction_hue_color_assert.svh
// ----------------------------------------------------------------------------
// vector_direction_hue_color_assert.svh
// assertion macros for the direction color wheel, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef VECTOR_DIRECTION_HUE_COLOR_ASSERT_SVH
`define VECTOR_DIRECTION_HUE_COLOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define VDHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdhc assertion failed");
// next-cycle implication
`define VDHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdhc assertion failed");
`else
`define VDHC_ASSERT_IMP(lbl, ante, cons)
`define VDHC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/vdhc_pkg.sv
// ----------------------------------------------------------------------------
// vdhc_pkg
// widths, constants and the arctangent table of the direction color wheel
// ----------------------------------------------------------------------------
package vdhc_pkg;

    localparam int IN_WIDTH      = 16;
    localparam int CORDIC_STAGES = 14;

    // cordic datapath
    localparam int XW        = IN_WIDTH + CORDIC_STAGES + 3;
    localparam int ANG_GUARD = 8;
    localparam int ZW        = 23;
    localparam int AW        = 14;
    localparam int ANG_TAB_LEN = 24;

    localparam logic signed [ZW-1:0] HALF_TURN_FINE = ZW'(4096 << ANG_GUARD);
    localparam logic signed [ZW-1:0] ROUND_HALF     = ZW'(1 << (ANG_GUARD - 1));
    localparam logic signed [ZW-1:0] ANGLE_MAX_Z    = ZW'(4096);
    localparam logic signed [AW-1:0] ANGLE_MAX      = AW'(4096);
    localparam logic signed [AW:0]   ANGLE_OFS      = (AW+1)'(4096);

    // color channel math, units of 1/12288
    localparam int FW   = AW;
    localparam int F3W  = FW + 1;
    localparam int VWW  = F3W + 1;
    localparam int VW   = 14;
    localparam int NW   = 22;
    localparam int MW   = 10;
    localparam int QW   = 20;
    localparam int CH_W = 8;
    localparam int NUM_CH = 3;

    localparam logic [VWW-1:0] ONE_UNIT = VWW'(12288);
    localparam logic [VWW-1:0] TWO_UNIT = VWW'(24576);
    localparam logic [VWW-1:0] HUE_SHIFT [NUM_CH] = '{VWW'(0), VWW'(8192), VWW'(16384)};
    localparam logic [NW-1:0]  CH_SCALE    = NW'(255);
    localparam logic [NW-1:0]  CH_ROUND    = NW'(6144);
    localparam logic [QW-1:0]  RECIP3      = QW'(683);
    localparam int             RECIP_SHIFT = 11;

    typedef logic [CH_W-1:0]          chan_t;
    typedef logic signed [IN_WIDTH-1:0] comp_t;

    function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
        logic signed [ZW-1:0] t;
        unique case (i)
            0:  t = ZW'(262144);
            1:  t = ZW'(154753);
            2:  t = ZW'(81767);
            3:  t = ZW'(41506);
            4:  t = ZW'(20834);
            5:  t = ZW'(10427);
            6:  t = ZW'(5215);
            7:  t = ZW'(2608);
            8:  t = ZW'(1304);
            9:  t = ZW'(652);
            10: t = ZW'(326);
            11: t = ZW'(163);
            12: t = ZW'(81);
            13: t = ZW'(41);
            14: t = ZW'(20);
            15: t = ZW'(10);
            16: t = ZW'(5);
            17: t = ZW'(3);
            18: t = ZW'(1);
            19: t = ZW'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

>>> hdl/vdhc_if.sv
// ----------------------------------------------------------------------------
// vdhc_if
// valid/ready channels: vector beats in, color beats out
// ----------------------------------------------------------------------------
interface vdhc_vec_if;
    import vdhc_pkg::*;

    logic  valid;
    logic  ready;
    comp_t x_component;
    comp_t y_component;

    modport source (output valid, output x_component, output y_component, input ready);
    modport sink   (input valid, input x_component, input y_component, output ready);
endinterface

interface vdhc_rgb_if;
    import vdhc_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> hdl/vector_direction_hue_color.sv
// ----------------------------------------------------------------------------
// vector_direction_hue_color
// maps the direction of a 2-D vector to an RGB hue through a pipelined
// vectoring CORDIC, or gives white when direction coloring is off
//
//   channel   dir   beat
//   vec       in    x_component, y_component
//   rgb       out   red, green, blue
//   cfg       in    cfg_wr_data (color_by_direction) on cfg_wr_en
//
// one beat per cycle while the output is not stalled; stages are the
// one-stage-per-iteration CORDIC plus prep, round, hue, fold, scale, output
// reset clears all valid bits and color_by_direction
// a full output register that is not taken holds the whole pipeline,
// and vec.ready drops for that cycle
// ----------------------------------------------------------------------------
`include "vector_direction_hue_color_assert.svh"

module vector_direction_hue_color (
    input  logic              clk,
    input  logic              rst_n,
    vdhc_vec_if.sink          vec,
    vdhc_rgb_if.source        rgb,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data
);
    import vdhc_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic en;
    logic color_reg;

    // cordic stages, index 0 is the prep stage
    logic signed [XW-1:0] x_reg  [0:N];
    logic signed [XW-1:0] y_reg  [0:N];
    logic signed [ZW-1:0] z_reg  [0:N];
    logic signed [XW-1:0] x_next [0:N];
    logic signed [XW-1:0] y_next [0:N];
    logic signed [ZW-1:0] z_next [0:N];
    logic [N:0]           zf_reg;
    logic [N:0]           cv_reg;

    logic signed [AW-1:0] a_reg, a_next;
    logic                 a_valid_reg;
    logic [F3W-1:0]       f3_reg, f3_next;
    logic                 f_valid_reg;
    logic [VW-1:0]        v_reg  [NUM_CH];
    logic [VW-1:0]        v_next [NUM_CH];
    logic                 v_valid_reg;
    logic [MW-1:0]        m_reg  [NUM_CH];
    logic [MW-1:0]        m_next [NUM_CH];
    logic                 m_valid_reg;
    chan_t                ch_reg  [NUM_CH];
    chan_t                ch_next [NUM_CH];
    logic                 out_valid_reg;

    logic signed [XW-1:0] xe, ye, xa, ya;
    logic                 neg_x;
    logic signed [ZW-1:0] zr, za;
    logic signed [AW:0]   f_sum;
    logic [FW-1:0]        f_val;
    logic                 in_zero;
    logic                 fold_ok;
    logic [N+5:0]         stage_valid;

    assign en        = !(out_valid_reg && !rgb.ready);
    assign vec.ready = en;

    assign rgb.valid = out_valid_reg;
    assign rgb.red   = ch_reg[0];
    assign rgb.green = ch_reg[1];
    assign rgb.blue  = ch_reg[2];

    assign in_zero = vec.x_component == '0 && vec.y_component == '0;

    // prep: fold left half plane, scale up
    always_comb
    begin
        xe    = XW'(vec.x_component);
        ye    = XW'(vec.y_component);
        neg_x = xe < 0;
        xa    = neg_x ? -xe : xe;
        ya    = neg_x ? -ye : ye;
        x_next[0] = xa <<< CORDIC_STAGES;
        y_next[0] = ya <<< CORDIC_STAGES;
        if (!neg_x)
        begin
            z_next[0] = '0;
        end
        else if (ya <= 0)
        begin
            z_next[0] = HALF_TURN_FINE;
        end
        else
        begin
            z_next[0] = -HALF_TURN_FINE;
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        always_comb
        begin
            if (y_reg[k] < 0)
            begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - atan_tab(k);
            end
            else
            begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + atan_tab(k);
            end
        end
    end

    // round to 2^-12 half-turn and saturate
    always_comb
    begin
        zr = z_reg[N] + ROUND_HALF;
        za = zr >>> ANG_GUARD;
        if (zf_reg[N])
        begin
            a_next = '0;
        end
        else if (za > ANGLE_MAX_Z)
        begin
            a_next = ANGLE_MAX;
        end
        else if (za < -ANGLE_MAX_Z)
        begin
            a_next = -ANGLE_MAX;
        end
        else
        begin
            a_next = za[AW-1:0];
        end
    end

    // f3 = 3 * (a + one half-turn)
    always_comb
    begin
        f_sum   = {a_reg[AW-1], a_reg} + ANGLE_OFS;
        f_val   = f_sum[FW-1:0];
        f3_next = F3W'({f_val, 1'b0}) + F3W'(f_val);
    end

    // wrap and fold per channel
    always_comb
    begin
        logic [VWW-1:0] vw, v1, v2;
        for (int c = 0; c < NUM_CH; c++)
        begin
            vw = VWW'(f3_reg) + HUE_SHIFT[c];
            v1 = (vw > TWO_UNIT) ? vw - TWO_UNIT : vw;
            v2 = (v1 > ONE_UNIT) ? TWO_UNIT - v1 : v1;
            v_next[c] = v2[VW-1:0];
        end
    end

    // scale to 0..255: n / 12288 as (n >> 12) / 3
    always_comb
    begin
        logic [NW-1:0] n;
        logic [QW-1:0] q;
        for (int c = 0; c < NUM_CH; c++)
        begin
            n = NW'(v_reg[c]) * CH_SCALE + CH_ROUND;
            m_next[c] = n[NW-1 -: MW];
            q = QW'(m_reg[c]) * RECIP3;
            ch_next[c] = color_reg ? q[RECIP_SHIFT +: CH_W] : '1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= 1'b0;
            cv_reg        <= '0;
            a_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            v_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
            if (en)
            begin
                cv_reg        <= {cv_reg[N-1:0], vec.valid};
                a_valid_reg   <= cv_reg[N];
                f_valid_reg   <= a_valid_reg;
                v_valid_reg   <= f_valid_reg;
                m_valid_reg   <= v_valid_reg;
                out_valid_reg <= m_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= N; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            zf_reg <= {zf_reg[N-1:0], in_zero};
            a_reg  <= a_next;
            f3_reg <= f3_next;
            for (int c = 0; c < NUM_CH; c++)
            begin
                v_reg[c]  <= v_next[c];
                m_reg[c]  <= m_next[c];
                ch_reg[c] <= ch_next[c];
            end
        end
    end

    assign stage_valid = {cv_reg, a_valid_reg, f_valid_reg, v_valid_reg,
                          m_valid_reg, out_valid_reg};

    assign fold_ok = v_reg[0] <= VW'(ONE_UNIT) && v_reg[1] <= VW'(ONE_UNIT) &&
                     v_reg[2] <= VW'(ONE_UNIT);

    `VDHC_ASSERT_NEXT(a_zero_tag, en && vec.valid && in_zero, zf_reg[0])
    `VDHC_ASSERT_IMP(a_angle_range, a_valid_reg, a_reg <= ANGLE_MAX && a_reg >= -ANGLE_MAX)
    `VDHC_ASSERT_IMP(a_fold_range, v_valid_reg, fold_ok)
    `VDHC_ASSERT_NEXT(a_stall_hold, !en, $stable(stage_valid))

endmodule

>>> tb/tb_vector_direction_hue_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_direction_hue_color
// streams 2-D vectors into the direction color wheel and checks every color
// beat against a bench cordic hue predictor or a fixed color, with random idle on
// the vector side and random stall on the color side, over both coloring modes
// ----------------------------------------------------------------------------
module tb_vector_direction_hue_color;
    import vdhc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * (CORDIC_STAGES + 6);
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 4;

    localparam longint HALF_TURN = 64'sd4096 <<< 8;
    localparam longint ONE_TURN_UNIT = 12288;
    localparam longint TWO_TURN_UNIT = 24576;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } color_t;

    typedef struct packed {
        logic   on;
        comp_t  x;
        comp_t  y;
        logic   typed;
        color_t want;
    } vec_case_t;

    typedef struct packed {
        logic   on;
        int     count;
        logic   steady;
    } phase_t;

    localparam color_t WHITE = '{8'd255, 8'd255, 8'd255};
    localparam color_t NO_COLOR = '{8'd0, 8'd0, 8'd0};

    // fine angle steps, units of 2^-20 half-turn
    localparam longint ATAN_FINE [24] = '{
        262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
        1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0, 0, 0, 0
    };

    localparam vec_case_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, 0, 0, 1'b1, WHITE},
        '{1'b0, 32767, -32768, 1'b1, WHITE},
        '{1'b0, -32768, 32767, 1'b1, WHITE},
        '{1'b1, 0, 0, 1'b1, '{8'd255, 8'd85, 8'd85}},
        '{1'b1, 1, 0, 1'b0, NO_COLOR},
        '{1'b1, -1, 0, 1'b0, NO_COLOR},
        '{1'b1, -32768, 0, 1'b0, NO_COLOR},
        '{1'b1, 32767, 0, 1'b0, NO_COLOR},
        '{1'b1, 0, 1, 1'b0, NO_COLOR},
        '{1'b1, 0, -1, 1'b0, NO_COLOR},
        '{1'b1, 0, 32767, 1'b0, NO_COLOR},
        '{1'b1, 0, -32768, 1'b0, NO_COLOR},
        '{1'b1, 32767, 32767, 1'b0, NO_COLOR},
        '{1'b1, -32768, -32768, 1'b0, NO_COLOR},
        '{1'b1, -32768, 32767, 1'b0, NO_COLOR},
        '{1'b1, 32767, -32768, 1'b0, NO_COLOR},
        '{1'b1, -1, -1, 1'b0, NO_COLOR},
        '{1'b1, -1, 1, 1'b0, NO_COLOR},
        '{1'b1, 1, -1, 1'b0, NO_COLOR},
        '{1'b1, -32768, -1, 1'b0, NO_COLOR},
        '{1'b1, -32768, 1, 1'b0, NO_COLOR},
        '{1'b1, 12345, -23456, 1'b0, NO_COLOR},
        '{1'b1, -20000, 7, 1'b0, NO_COLOR},
        '{1'b1, -7, -20000, 1'b0, NO_COLOR},
        '{1'b0, -1, -1, 1'b1, WHITE}
    };

    localparam phase_t PHASES [N_PHASES] = '{
        '{1'b1, 600, 1'b0},
        '{1'b0, 200, 1'b0},
        '{1'b1, 450, 1'b1},
        '{1'b1, 600, 1'b0}
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    vdhc_vec_if vec_bus ();
    vdhc_rgb_if rgb_bus ();

    vector_direction_hue_color uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec         (vec_bus.sink),
        .rgb         (rgb_bus.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    color_t pending_colors [$];
    logic   direction_on;
    logic   no_stall_stretch;
    int     mismatch_count;
    int     quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic chan_t hue_level(input longint v);
        longint w;
        w = v;
        if (w > TWO_TURN_UNIT)
            w = w - TWO_TURN_UNIT;
        if (w > ONE_TURN_UNIT)
            w = TWO_TURN_UNIT - w;
        return chan_t'((w * 255 + ONE_TURN_UNIT / 2) / ONE_TURN_UNIT);
    endfunction

    function automatic color_t predict_color(input logic on, input comp_t xc, input comp_t yc);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint a;
        longint f3;
        color_t c;
        if (!on)
            return WHITE;
        x = xc;
        y = yc;
        z = 0;
        a = 0;
        if (x != 0 || y != 0)
        begin
            // left half-plane: rotate by a half-turn first
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = (y <= 0) ? HALF_TURN : -HALF_TURN;
            end
            x = x <<< CORDIC_STAGES;
            y = y <<< CORDIC_STAGES;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y < 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ((i < 24) ? ATAN_FINE[i] : 0);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ((i < 24) ? ATAN_FINE[i] : 0);
                end
            end
            a = (z + 128) >>> 8;
            if (a > 4096)
                a = 4096;
            if (a < -4096)
                a = -4096;
        end
        f3 = 3 * (a + 4096);
        c.red   = hue_level(f3);
        c.green = hue_level(f3 + 8192);
        c.blue  = hue_level(f3 + 16384);
        return c;
    endfunction

    function automatic logic take_break();
        return !no_stall_stretch && ($urandom_range(0, 99) < 29);
    endfunction

    task automatic send_vector(input comp_t xc, input comp_t yc, input logic typed,
                               input color_t want);
        if (take_break())
        begin
            vec_bus.valid <= 1'b0;
            @(posedge clk);
            while (take_break())
                @(posedge clk);
        end
        vec_bus.valid       <= 1'b1;
        vec_bus.x_component <= xc;
        vec_bus.y_component <= yc;
        @(posedge clk);
        while (!vec_bus.ready)
            @(posedge clk);
        pending_colors.push_back(typed ? want : predict_color(direction_on, xc, yc));
    endtask

    task automatic set_direction(input logic on);
        vec_bus.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        direction_on = on;
    endtask

    // color side: check each beat, then pick the next ready
    initial
    begin
        color_t exp_color;
        rgb_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rgb_bus.valid && rgb_bus.ready)
            begin
                if (pending_colors.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected color beat r=%0d g=%0d b=%0d",
                                 rgb_bus.red, rgb_bus.green, rgb_bus.blue);
                    mismatch_count++;
                end
                else
                begin
                    exp_color = pending_colors.pop_front();
                    if (rgb_bus.red !== exp_color.red || rgb_bus.green !== exp_color.green ||
                        rgb_bus.blue !== exp_color.blue)
                    begin
                        if (mismatch_count < 10)
                            $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     exp_color.red, exp_color.green, exp_color.blue,
                                     rgb_bus.red, rgb_bus.green, rgb_bus.blue);
                        mismatch_count++;
                    end
                end
            end
            rgb_bus.ready <= !take_break();
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((vec_bus.valid && vec_bus.ready) || (rgb_bus.valid && rgb_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        comp_t rx;
        comp_t ry;
        int    pick;
        mismatch_count   = 0;
        direction_on     = 1'b0;
        no_stall_stretch = 1'b0;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= 1'b0;
        vec_bus.valid       <= 1'b0;
        vec_bus.x_component <= '0;
        vec_bus.y_component <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].on != direction_on)
                set_direction(DIRECTED[i].on);
            send_vector(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_direction(PHASES[p].on);
            no_stall_stretch = PHASES[p].steady;
            for (int n = 0; n < PHASES[p].count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    rx = comp_t'($urandom);
                    ry = comp_t'($urandom);
                end
                else if (pick < 75)
                begin
                    rx = comp_t'($urandom_range(0, 16)) - comp_t'(8);
                    ry = comp_t'($urandom_range(0, 16)) - comp_t'(8);
                end
                else if (pick < 88)
                begin
                    // axes and diagonals
                    rx = comp_t'($urandom);
                    case ($urandom_range(0, 3))
                        0: ry = '0;
                        1: ry = rx;
                        2: ry = -rx;
                        default:
                        begin
                            ry = rx;
                            rx = '0;
                        end
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0: rx = -32768;
                        1: rx = -32767;
                        2: rx = -1;
                        3: rx = 0;
                        4: rx = 1;
                        default: rx = 32767;
                    endcase
                    case ($urandom_range(0, 5))
                        0: ry = -32768;
                        1: ry = -32767;
                        2: ry = -1;
                        3: ry = 0;
                        4: ry = 1;
                        default: ry = 32767;
                    endcase
                end
                send_vector(rx, ry, 1'b0, NO_COLOR);
            end
        end

        no_stall_stretch = 1'b0;
        vec_bus.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_colors.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
